/* rtl/dual_subsequence_length_tracker_unit_defines.svh */
// Assertion macros for the dual subsequence length tracker.
// Define ASSERT_OFF to compile the checks out.
`ifndef DUAL_SUBSEQUENCE_LENGTH_TRACKER_UNIT_DEFINES_SVH
`define DUAL_SUBSEQUENCE_LENGTH_TRACKER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define DSLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define DSLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSLT_ASSERT(lbl, clk, rstn, prop, msg)
`define DSLT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/dslt_pkg.sv */
// Shared types and constants for the dual subsequence length tracker.
// No dependencies.
`timescale 1ns / 1ps
package dslt_pkg;
  localparam int VALUE_W = 16;
  localparam int LEN_W   = 11;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               start_req;
  } in_word_t;

  typedef struct packed {
    logic [LEN_W-1:0] nonincreasing_length;
    logic [LEN_W-1:0] increasing_length;
    logic             overflow;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic start;
    logic read_last;
    logic decide;
    logic search;
  } tbl_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             ovf;
    logic [LEN_W-1:0] len;
  } tbl_stat_t;
endpackage

/* rtl/dual_subsequence_length_tracker_unit.sv */
// Dual subsequence length tracker: patience-sort tail tables, binary search.
// Per word: S_IDLE loads it, S_LAST reads the last tails, S_DECIDE appends or starts
// a search, S_SEARCH runs the binary search and S_OUT fills the result register.
// A new word waits until S_IDLE; in the search each table makes one RAM probe per cycle.
// The next word is taken while a finished result still waits on out_stall.
// Reset (rst_n low, synchronous) empties both tables; tail RAMs are not cleared.
`timescale 1ns / 1ps
`include "dual_subsequence_length_tracker_unit_defines.svh"
module dual_subsequence_length_tracker_unit
  import dslt_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);
  tbl_cmd_t  cmd;
  tbl_stat_t stat_desc, stat_asc;
  logic      in_acc, tbl_idle;

  assign in_acc   = in_valid && !in_stall;
  assign tbl_idle = !stat_desc.busy && !stat_asc.busy;

  dslt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .start_req (in_word.start_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .stat_desc (stat_desc),
    .stat_asc  (stat_asc)
  );

  dslt_table #(.MAX_LEN(MAX_LEN), .VALUE_BITS(VALUE_BITS), .DESC(1'b1)) u_desc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .value (in_word.value),
    .stat  (stat_desc)
  );

  dslt_table #(.MAX_LEN(MAX_LEN), .VALUE_BITS(VALUE_BITS), .DESC(1'b0)) u_asc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .value (in_word.value),
    .stat  (stat_asc)
  );

  `DSLT_ASSERT(a_busy_after_accept, clk, rst_n, in_acc |=> in_stall, "accept did not start work")
  `DSLT_ASSERT(a_ready_tables_idle, clk, rst_n, !in_stall |-> tbl_idle, "ready while a search runs")
  `DSLT_ASSERT(a_decide_then_search, clk, rst_n, cmd.decide |=> cmd.search, "no search after decide")
  `DSLT_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (!out_valid && !in_stall), "reset left block busy")
endmodule

/* rtl/dslt_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dslt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/dslt_table.sv */
// Tail table datapath: tail RAM, count, and binary search bounds for one table.
// Depends on dslt_pkg and dslt_ram.
`timescale 1ns / 1ps
module dslt_table
  import dslt_pkg::*;
#(
  parameter int MAX_LEN    = 1024,
  parameter int VALUE_BITS = 16,
  parameter bit DESC       = 1'b1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tbl_cmd_t           cmd,
  input  logic [VALUE_W-1:0] value,
  output tbl_stat_t          stat
);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic                  busy_r, busy_nxt, pend_r, pend_nxt, ovf_r, ovf_nxt;

  logic [AW-1:0]         lo_n, hi_n, mid_n, waddr, raddr;
  logic                  we, hit;
  logic [VALUE_BITS-1:0] rdata;

  dslt_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_LEN)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (v_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // hit: search moves left of the probed tail
  assign hit = DESC ? (rdata < v_r) : (rdata >= v_r);

  always_comb begin
    lo_n = lo_r;
    hi_n = hi_r;
    if (pend_r) begin
      if (hit) begin
        hi_n = mid_r;
      end else begin
        lo_n = mid_r + AW'(1);
      end
    end
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  always_comb begin
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    v_nxt     = v_r;
    busy_nxt  = busy_r;
    pend_nxt  = pend_r;
    ovf_nxt   = ovf_r;
    we        = 1'b0;
    waddr     = lo_n;
    raddr     = mid_n;

    if (cmd.load) begin
      v_nxt    = VALUE_BITS'(value);
      ovf_nxt  = 1'b0;
      busy_nxt = 1'b0;
      pend_nxt = 1'b0;
      if (cmd.start) begin
        count_nxt = '0;
      end
    end

    if (cmd.read_last) begin
      raddr = AW'(count_r - CW'(1));
    end

    if (cmd.decide) begin
      if (count_r == '0 || !hit) begin
        if (count_r < MAX_CNT) begin
          we        = 1'b1;
          waddr     = AW'(count_r);
          count_nxt = count_r + CW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else begin
        // last tail already qualifies, so search at or below it
        busy_nxt = 1'b1;
        pend_nxt = 1'b0;
        lo_nxt   = '0;
        hi_nxt   = AW'(count_r - CW'(1));
      end
    end

    if (cmd.search && busy_r) begin
      lo_nxt = lo_n;
      hi_nxt = hi_n;
      if (lo_n < hi_n) begin
        raddr    = mid_n;
        mid_nxt  = mid_n;
        pend_nxt = 1'b1;
      end else begin
        we       = 1'b1;
        waddr    = lo_n;
        busy_nxt = 1'b0;
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      pend_r  <= pend_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    v_r   <= v_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.ovf  = ovf_r;
  assign stat.len  = LEN_W'(count_r);
endmodule

/* rtl/dslt_ctrl.sv */
// Sequencer for both tail tables plus the result word register.
// Depends on dslt_pkg.
`timescale 1ns / 1ps
module dslt_ctrl
  import dslt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      start_req,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  output tbl_cmd_t  cmd,
  input  tbl_stat_t stat_desc,
  input  tbl_stat_t stat_asc
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_LAST   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SEARCH = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t    state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.start     = start_req;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        cmd.read_last = 1'b1;
        state_nxt     = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_SEARCH;
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (!stat_desc.busy && !stat_asc.busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_word_nxt.nonincreasing_length = stat_desc.len;
          out_word_nxt.increasing_length    = stat_asc.len;
          out_word_nxt.overflow             = stat_desc.ovf | stat_asc.ovf;
          out_valid_nxt                     = 1'b1;
          state_nxt                         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule

/* tb/sv/dual_subsequence_length_tracker_unit_test.sv */
// Testbench for dual_subsequence_length_tracker_unit: directed table, then random runs.
// Known rows give their lengths, others a patience-sort tracker; depends on dslt_pkg.
`timescale 1ns / 1ps
module dual_subsequence_length_tracker_unit_test;
  import dslt_pkg::*;

  localparam int TAIL_DEPTH = 1024;
  localparam int RANDOM_WORDS = 728;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DIR_N = 22;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               start;
    logic               known;
    logic [LEN_W-1:0]   nonincr;
    logic [LEN_W-1:0]   incr;
    logic               ovf;
  } dir_row_t;

  typedef struct {
    in_word_t  w;
    bit        known;
    out_word_t want;
  } feed_word_t;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{16'd100,   1'b1, 1'b1, 11'd1, 11'd1, 1'b0},
    '{16'd100,   1'b0, 1'b1, 11'd2, 11'd1, 1'b0},
    '{16'd0,     1'b0, 1'b1, 11'd3, 11'd1, 1'b0},
    '{16'hFFFF,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'hFFFF,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'd0,     1'b1, 1'b1, 11'd1, 11'd1, 1'b0},
    '{16'd1,     1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'd2,     1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'd3,     1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'hFFFF,  1'b1, 1'b1, 11'd1, 11'd1, 1'b0},
    '{16'd0,     1'b0, 1'b1, 11'd2, 11'd1, 1'b0},
    '{16'h8000,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'h4000,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'hC000,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'h2000,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'hFFFF,  1'b1, 1'b1, 11'd1, 11'd1, 1'b0},
    '{16'h5555,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'hAAAA,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'd1,     1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'h8000,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'h7FFF,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0},
    '{16'hFFFE,  1'b0, 1'b0, 11'd0, 11'd0, 1'b0}
  };

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  feed_word_t value_feed[$];
  out_word_t  pending_lengths[$];

  logic [VALUE_W-1:0] desc_tail [TAIL_DEPTH];
  logic [VALUE_W-1:0] asc_tail [TAIL_DEPTH];
  int desc_len = 0;
  int asc_len = 0;

  int sent_count = 0;
  int got_count = 0;
  int mismatches = 0;
  int cycles = 0;
  int hold_left = 0;
  bit held = 0;
  wire calm = (sent_count >= 450) && (sent_count < 650);

  dual_subsequence_length_tracker_unit #(
    .MAX_LEN(TAIL_DEPTH),
    .VALUE_BITS(VALUE_W)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // patience sort: desc table non-increasing, asc table strictly increasing
  function automatic out_word_t track_value(in_word_t w);
    out_word_t r;
    int lo, hi, mid;
    logic [VALUE_W-1:0] v;
    r = '0;
    v = w.value;
    if (w.start_req) begin
      desc_len = 0;
      asc_len = 0;
    end
    if (desc_len == 0 || v <= desc_tail[desc_len-1]) begin
      if (desc_len < TAIL_DEPTH) begin
        desc_tail[desc_len] = v;
        desc_len++;
      end else begin
        r.overflow = 1'b1;
      end
    end else begin
      lo = 0;
      hi = desc_len;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (desc_tail[mid] < v) hi = mid;
        else lo = mid + 1;
      end
      if (lo < desc_len) desc_tail[lo] = v;
    end
    if (asc_len == 0 || v > asc_tail[asc_len-1]) begin
      if (asc_len < TAIL_DEPTH) begin
        asc_tail[asc_len] = v;
        asc_len++;
      end else begin
        r.overflow = 1'b1;
      end
    end else begin
      lo = 0;
      hi = asc_len;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (asc_tail[mid] >= v) hi = mid;
        else lo = mid + 1;
      end
      if (lo < asc_len) asc_tail[lo] = v;
    end
    r.nonincreasing_length = LEN_W'(desc_len);
    r.increasing_length = LEN_W'(asc_len);
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return VALUE_W'($urandom_range(0, 15));
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic queue_word(logic [VALUE_W-1:0] v, logic s);
    feed_word_t f;
    f.w.value = v;
    f.w.start_req = s;
    f.known = 1'b0;
    f.want = '0;
    value_feed.push_back(f);
  endtask

  // sender
  always @(posedge clk) begin : drive_in
    logic nv;
    in_word_t nw;
    out_word_t pred;
    nv = in_valid;
    nw = in_word;
    if (!rst_n) begin
      nv = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pred = track_value(in_word);
        pending_lengths.push_back(value_feed[0].known ? value_feed[0].want : pred);
        void'(value_feed.pop_front());
        sent_count <= sent_count + 1;
        nv = 1'b0;
      end
      if (!nv && value_feed.size() > 0 && (calm || $urandom_range(0, 99) >= 7)) begin
        nv = 1'b1;
        nw = value_feed[0].w;
      end
    end
    in_valid <= nv;
    in_word <= nw;
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!held && got_count >= HOLD_AT) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin : check_out
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      got_count <= got_count + 1;
      if (pending_lengths.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: got %0d %0d %0d", out_word.nonincreasing_length,
                   out_word.increasing_length, out_word.overflow);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_lengths.pop_front();
        if (out_word.nonincreasing_length !== want.nonincreasing_length ||
            out_word.increasing_length !== want.increasing_length ||
            out_word.overflow !== want.overflow) begin
          if (mismatches < 10)
            $display("word %0d: expected %0d %0d %0d, got %0d %0d %0d", got_count,
                     want.nonincreasing_length, want.increasing_length, want.overflow,
                     out_word.nonincreasing_length, out_word.increasing_length,
                     out_word.overflow);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : main
    feed_word_t f;
    int made, run, mode, v;
    for (int i = 0; i < DIR_N; i++) begin
      f.w.value = DIR_ROWS[i].value;
      f.w.start_req = DIR_ROWS[i].start;
      f.known = DIR_ROWS[i].known;
      f.want.nonincreasing_length = DIR_ROWS[i].nonincr;
      f.want.increasing_length = DIR_ROWS[i].incr;
      f.want.overflow = DIR_ROWS[i].ovf;
      value_feed.push_back(f);
    end
    made = 0;
    while (made < RANDOM_WORDS) begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 30);
      mode = $urandom_range(0, 2);
      v = $urandom_range(0, 65535);
      for (int i = 0; i < run; i++) begin
        case (mode)
          0: v = pick_value();
          1: v = (v + $urandom_range(0, 300) > 65535) ? 65535 : v + $urandom_range(0, 300);
          default: v = (v < 300) ? $urandom_range(0, v) : v - $urandom_range(0, 300);
        endcase
        queue_word(VALUE_W'(v), (i == 0 && $urandom_range(0, 49) != 0) ||
                   $urandom_range(0, 99) < 3);
      end
      made += run;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (value_feed.size() > 0 || in_valid) @(posedge clk);
    while (pending_lengths.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_lengths.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_lengths.size() > 0)
        $display("%0d expected words never arrived", pending_lengths.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
